>>> src/irs_pkg.sv
// Shared types, register codes and helpers for the image resize interpolator.
// No dependencies; every other file but irs_ram refers to it by scoped names.
`default_nettype none
package irs_pkg;

  localparam int ONE_Q16 = 65536;
  localparam int HALF_Q16 = 32768;
  localparam int SCALE_BITS = 25;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_NUM_CHAN   = 3'd2;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd4;
  localparam logic [2:0] REG_INTERP     = 3'd5;

  // effective settings seen by the front end
  typedef struct packed {
    logic [8:0]            sw;
    logic [8:0]            sh;
    logic [2:0]            nc;
    logic                  bilinear;
    logic [SCALE_BITS-1:0] scale_x;
    logic [SCALE_BITS-1:0] scale_y;
  } cfg_t;

  // one queued operation between front and back
  typedef struct packed {
    logic        is_load;
    logic        bilinear;
    logic [15:0] fx;
    logic [15:0] fy;
  } ctl_t;

  function automatic logic [7:0] clamp_idx(input logic signed [18:0] v,
                                           input logic [8:0] last);
    logic signed [18:0] l;
    l = $signed({10'b0, last});
    if (v < 0) return 8'd0;
    else if (v > l) return last[7:0];
    else return v[7:0];
  endfunction

endpackage
`default_nettype wire

>>> src/irs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module irs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> src/irs_scale_div.sv
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// No dependencies beyond irs_pkg.
`default_nettype none
module irs_scale_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [8:0]                      num,
  input  wire logic [8:0]                      den,
  output logic                                 busy,
  output logic [irs_pkg::SCALE_BITS-1:0]       quot
);
  localparam int QB = irs_pkg::SCALE_BITS;

  logic          running;
  logic [4:0]    cnt;
  logic [8:0]    rem;
  logic [QB-1:0] dvd;
  logic [8:0]    dreg;
  logic [9:0]    trial;

  assign trial = {rem, dvd[QB-1]};
  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
      quot <= QB'(irs_pkg::ONE_Q16);
    end else if (start) begin
      running <= 1'b1;
      cnt <= '0;
      rem <= '0;
      dvd <= {num, 16'b0};
      dreg <= den;
      quot <= '0;
    end else if (running) begin
      if (trial >= {1'b0, dreg}) begin
        rem <= 9'(trial - {1'b0, dreg});
        quot <= {quot[QB-2:0], 1'b1};
      end else begin
        rem <= trial[8:0];
        quot <= {quot[QB-2:0], 1'b0};
      end
      dvd <= {dvd[QB-2:0], 1'b0};
      cnt <= cnt + 5'd1;
      if (cnt == 5'(QB - 1)) running <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> src/irs_front.sv
// Front end: takes items, maps destination coordinates to source positions
// and store addresses, and hands operations to the back end. Uses irs_pkg.
`default_nettype none
module irs_front #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int AW = 18
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire irs_pkg::cfg_t           cfg,
  input  wire logic                    take,
  input  wire logic                    kind,
  input  wire logic [7:0]              col,
  input  wire logic [7:0]              row,
  input  wire logic [1:0]              channel,
  input  wire logic [15:0]             sample_in,
  output logic                         ready,
  output logic                         q_push,
  output irs_pkg::ctl_t                q_ctl,
  output logic [3:0][AW-1:0]           q_addr,
  output logic [SAMPLE_BITS-1:0]       q_wdata,
  input  wire logic                    q_ready
);
  localparam int QB = irs_pkg::SCALE_BITS;

  logic                   f1_valid;
  logic                   f1_kind;
  logic [7:0]             f1_col, f1_row;
  logic [1:0]             f1_ch;
  logic [SAMPLE_BITS-1:0] f1_smp;
  logic [QB+7:0]          f1_px, f1_py;

  function automatic logic signed [QB+9:0] coord(input logic [QB+7:0] p,
                                                 input logic [QB-1:0] s);
    logic signed [QB+1:0] h;
    h = ($signed({2'b0, s}) - (QB+2)'(irs_pkg::ONE_Q16)) >>> 1;
    return $signed({2'b0, p}) + (QB+10)'(h);
  endfunction

  function automatic logic [7:0] near_idx(input logic signed [QB+9:0] c,
                                          input logic [8:0] last);
    logic [QB+8:0] t;
    t = c[QB+8:0] + (QB+9)'(irs_pkg::HALF_Q16);
    if (c[QB+9]) return 8'd0;
    else if (c[QB+8:0] > {9'b0, last, 16'b0}) return last[7:0];
    else return t[23:16];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y,
                                            input logic [1:0] ch);
    return AW'((int'(y) * MAX_WIDTH + int'(x)) * MAX_CHANNELS + int'(ch));
  endfunction

  logic signed [QB+9:0] cx, cy;
  logic [8:0]  lastx, lasty;
  logic [1:0]  chc;
  logic [7:0]  x0, x1, y0, y1, nx, ny;
  logic signed [18:0] x0s, y0s;
  logic        in_bounds;

  always_comb begin
    cx = coord(f1_px, cfg.scale_x);
    cy = coord(f1_py, cfg.scale_y);
    lastx = cfg.sw - 9'd1;
    lasty = cfg.sh - 9'd1;
    chc = ({1'b0, f1_ch} >= cfg.nc) ? 2'(cfg.nc - 3'd1) : f1_ch;
    x0s = cx[QB+9:16];
    y0s = cy[QB+9:16];
    x0 = irs_pkg::clamp_idx(x0s, lastx);
    x1 = irs_pkg::clamp_idx(x0s + 19'sd1, lastx);
    y0 = irs_pkg::clamp_idx(y0s, lasty);
    y1 = irs_pkg::clamp_idx(y0s + 19'sd1, lasty);
    nx = near_idx(cx, lastx);
    ny = near_idx(cy, lasty);
    in_bounds = (int'(f1_col) < MAX_WIDTH) && (int'(f1_row) < MAX_HEIGHT) &&
                (int'(f1_ch) < MAX_CHANNELS);

    q_ctl.is_load = !f1_kind;
    q_ctl.bilinear = cfg.bilinear;
    q_ctl.fx = cx[15:0];
    q_ctl.fy = cy[15:0];
    q_wdata = f1_smp;
    if (!f1_kind) begin
      q_addr[0] = addr_of(f1_col, f1_row, f1_ch);
      q_addr[1] = q_addr[0];
      q_addr[2] = q_addr[0];
      q_addr[3] = q_addr[0];
    end else if (cfg.bilinear) begin
      q_addr[0] = addr_of(x0, y0, chc);
      q_addr[1] = addr_of(x1, y0, chc);
      q_addr[2] = addr_of(x0, y1, chc);
      q_addr[3] = addr_of(x1, y1, chc);
    end else begin
      q_addr[0] = addr_of(nx, ny, chc);
      q_addr[1] = q_addr[0];
      q_addr[2] = q_addr[0];
      q_addr[3] = q_addr[0];
    end
    // loads outside the store are dropped here
    q_push = f1_valid && q_ready && (f1_kind || in_bounds);
  end

  assign ready = !f1_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (ready) begin
      f1_valid <= take;
    end
    if (take) begin
      f1_kind <= kind;
      f1_col <= col;
      f1_row <= row;
      f1_ch <= channel;
      f1_smp <= SAMPLE_BITS'(sample_in);
      f1_px <= (QB+8)'(col * cfg.scale_x);
      f1_py <= (QB+8)'(row * cfg.scale_y);
    end
  end
endmodule
`default_nettype wire

>>> src/irs_back.sv
// Back end: operation queue, image store sequencing, bilinear blend pipeline
// and result buffer. Uses irs_pkg and irs_ram.
`default_nettype none
module irs_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int DEPTH = 262144,
  parameter int AW = 18
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire irs_pkg::ctl_t           ctl,
  input  wire logic [3:0][AW-1:0]      addr,
  input  wire logic [SAMPLE_BITS-1:0]  wdata,
  output logic                         q_ready,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic [15:0]                  sample_out
);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 17;
  localparam int MW = PW + 17;

  // operation queue
  irs_pkg::ctl_t          qctl [4];
  logic [3:0][AW-1:0]     qaddr [4];
  logic [SB-1:0]          qwd [4];
  logic [1:0]             qwp, qrp;
  logic [2:0]             qcnt;
  logic                   q_pop;
  irs_pkg::ctl_t          hctl;

  assign q_ready = qcnt != 3'd4;
  assign hctl = qctl[qrp];

  always_ff @(posedge clk) begin
    if (rst) begin
      qwp <= '0;
      qrp <= '0;
      qcnt <= '0;
    end else begin
      if (push) qwp <= qwp + 2'd1;
      if (q_pop) qrp <= qrp + 2'd1;
      qcnt <= qcnt + {2'b0, push} - {2'b0, q_pop};
    end
    if (push) begin
      qctl[qwp] <= ctl;
      qaddr[qwp] <= addr;
      qwd[qwp] <= wdata;
    end
  end

  // store sequencer
  logic [1:0]    k;
  logic [2:0]    inflight, ocnt;
  logic          credit_ok, rd_issue, rd_start, rd_last, ram_we;
  logic [AW-1:0] ram_addr;
  logic [SB-1:0] ram_rdata;
  logic [16:0]   gx;
  logic          b2_valid;

  assign credit_ok = ({1'b0, inflight} + {1'b0, ocnt}) < 4'd4;
  assign gx = 17'(irs_pkg::ONE_Q16) - {1'b0, hctl.fx};

  always_comb begin
    ram_we = 1'b0;
    rd_issue = 1'b0;
    rd_start = 1'b0;
    rd_last = 1'b0;
    q_pop = 1'b0;
    ram_addr = qaddr[qrp][k];
    if (qcnt != 3'd0) begin
      if (hctl.is_load) begin
        ram_we = 1'b1;
        ram_addr = qaddr[qrp][0];
        q_pop = 1'b1;
      end else if (k != 2'd0 || credit_ok) begin
        rd_issue = 1'b1;
        rd_start = k == 2'd0;
        rd_last = !hctl.bilinear || k == 2'd3;
        q_pop = rd_last;
      end
    end
  end

  irs_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(qwd[qrp]),
    .rdata(ram_rdata)
  );

  // tag travelling with each read
  logic        d_valid, d_first, d_row_end, d_bot, d_final;
  logic [16:0] d_wx, d_gy;
  logic [15:0] d_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      d_valid <= 1'b0;
    end else begin
      d_valid <= rd_issue;
      if (rd_issue) k <= rd_last ? 2'd0 : k + 2'd1;
    end
    d_first <= !k[0];
    d_row_end <= k[0] || !hctl.bilinear;
    d_bot <= k[1];
    d_final <= rd_last;
    if (!hctl.bilinear) d_wx <= 17'(irs_pkg::ONE_Q16);
    else if (k[0]) d_wx <= {1'b0, hctl.fx};
    else d_wx <= gx;
    d_gy <= hctl.bilinear ? 17'(irs_pkg::ONE_Q16) - {1'b0, hctl.fy}
                          : 17'(irs_pkg::ONE_Q16);
    d_fy <= hctl.bilinear ? hctl.fy : 16'd0;
  end

  // horizontal blend, one sample a cycle as store reads arrive
  logic [PW-1:0] acc, acc_next, top_hold;
  logic          b1_valid;
  logic [PW-1:0] b1_top, b1_bot;
  logic [16:0]   b1_gy;
  logic [15:0]   b1_fy;

  assign acc_next = (d_first ? '0 : acc) + PW'(ram_rdata * d_wx);

  // vertical blend and rounding
  logic [MW-1:0] b2_mt, b2_mb;
  logic [MW:0]   sum;
  assign sum = {1'b0, b2_mt} + {1'b0, b2_mb} + (MW+1)'(64'd1 << 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= d_valid && d_final;
      b2_valid <= b1_valid;
    end
    if (d_valid) acc <= acc_next;
    if (d_valid && d_row_end && !d_bot) top_hold <= acc_next;
    if (d_valid && d_final) begin
      b1_top <= d_bot ? top_hold : acc_next;
      b1_bot <= d_bot ? acc_next : '0;
      b1_gy <= d_gy;
      b1_fy <= d_fy;
    end
    b2_mt <= MW'(b1_top * b1_gy);
    b2_mb <= MW'(b1_bot * b1_fy);
  end

  // result buffer
  logic [15:0] ofifo [4];
  logic [1:0]  owp, orp;
  logic        o_pop;

  assign result_valid = ocnt != 3'd0;
  assign sample_out = ofifo[orp];
  assign o_pop = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0;
      orp <= '0;
      ocnt <= '0;
      inflight <= '0;
    end else begin
      if (b2_valid) owp <= owp + 2'd1;
      if (o_pop) orp <= orp + 2'd1;
      ocnt <= ocnt + {2'b0, b2_valid} - {2'b0, o_pop};
      inflight <= inflight + {2'b0, rd_issue && rd_start} - {2'b0, b2_valid};
    end
    if (b2_valid) ofifo[owp] <= 16'(sum >> 32);
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, inflight} + {1'b0, ocnt}) <= 4'd4)
    else $error("requests in flight exceed result buffer room");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> qcnt != 3'd0)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b2_valid |-> ocnt != 3'd4)
    else $error("result buffer overflow");
endmodule
`default_nettype wire

>>> src/image_resize_interpolator.sv
// Image resize interpolator top level: configuration registers, scale
// dividers, front end and back end. Uses irs_pkg, irs_scale_div, irs_front, irs_back.
// A load item takes one write of the single-port image store; a request takes one
// store read in nearest mode and four in bilinear mode. Loads run at one per cycle
// while item_stall is low; requests overlap in the store and the blend pipeline,
// limited by the result buffer credit. A request passes the front-end register,
// the operation queue, the store read, the horizontal and vertical blend
// registers and the result buffer. After each write to a width or
// height register the block recomputes the scale factors in two bit-serial
// dividers and holds item_stall high until both finish. The store has no reset;
// read only locations that have been loaded.
`default_nettype none
module image_resize_interpolator #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  col,
  input  wire logic [7:0]  row,
  input  wire logic [1:0]  channel,
  input  wire logic [15:0] sample_in,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [15:0]      sample_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int AW = $clog2(DEPTH);

  logic [8:0] src_width, src_height, dst_width, dst_height;
  logic [2:0] num_channels;
  logic       interp_mode;
  logic       div_start, busy_x, busy_y;
  logic       cfg_wr;
  logic [irs_pkg::SCALE_BITS-1:0] scale_x, scale_y;
  irs_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= 9'd1;
      src_height <= 9'd1;
      num_channels <= 3'd1;
      dst_width <= 9'd1;
      dst_height <= 9'd1;
      interp_mode <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_index)
          irs_pkg::REG_SRC_WIDTH: begin
            src_width <= cfg_data;
            div_start <= 1'b1;
          end
          irs_pkg::REG_SRC_HEIGHT: begin
            src_height <= cfg_data;
            div_start <= 1'b1;
          end
          irs_pkg::REG_NUM_CHAN: num_channels <= cfg_data[2:0];
          irs_pkg::REG_DST_WIDTH: begin
            dst_width <= cfg_data;
            div_start <= 1'b1;
          end
          irs_pkg::REG_DST_HEIGHT: begin
            dst_height <= cfg_data;
            div_start <= 1'b1;
          end
          irs_pkg::REG_INTERP: interp_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  logic [8:0] dw_eff, dh_eff;

  always_comb begin
    cfg.sw = (src_width == 9'd0) ? 9'd1 :
             ({23'b0, src_width} > MAX_WIDTH) ? 9'(MAX_WIDTH) : src_width;
    cfg.sh = (src_height == 9'd0) ? 9'd1 :
             ({23'b0, src_height} > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : src_height;
    cfg.nc = (num_channels == 3'd0) ? 3'd1 :
             ({29'b0, num_channels} > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : num_channels;
    cfg.bilinear = interp_mode;
    cfg.scale_x = scale_x;
    cfg.scale_y = scale_y;
    dw_eff = (dst_width == 9'd0) ? 9'd1 : dst_width;
    dh_eff = (dst_height == 9'd0) ? 9'd1 : dst_height;
  end

  irs_scale_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(cfg.sw), .den(dw_eff),
    .busy(busy_x), .quot(scale_x)
  );

  irs_scale_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(cfg.sh), .den(dh_eff),
    .busy(busy_y), .quot(scale_y)
  );

  logic                   front_ready, take, q_push, q_ready;
  irs_pkg::ctl_t          q_ctl;
  logic [3:0][AW-1:0]     q_addr;
  logic [SAMPLE_BITS-1:0] q_wdata;

  assign item_stall = div_start || busy_x || busy_y || !front_ready;
  assign take = item_valid && !item_stall;

  irs_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_CHANNELS(MAX_CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS), .AW(AW)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .take(take), .kind(kind), .col(col),
    .row(row), .channel(channel), .sample_in(sample_in), .ready(front_ready),
    .q_push(q_push), .q_ctl(q_ctl), .q_addr(q_addr), .q_wdata(q_wdata),
    .q_ready(q_ready)
  );

  irs_back #(.SAMPLE_BITS(SAMPLE_BITS), .DEPTH(DEPTH), .AW(AW)) u_back (
    .clk(clk), .rst(rst), .push(q_push), .ctl(q_ctl), .addr(q_addr),
    .wdata(q_wdata), .q_ready(q_ready), .result_valid(result_valid),
    .result_stall(result_stall), .sample_out(sample_out)
  );
endmodule
`default_nettype wire
